// ----- hdl/btlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared constants, types and helpers of the binary trie longest prefix
// match core.
// ----------------------------------------------------------------------------
package btlpm_pkg;

   localparam int NODE_COUNT   = 4096;
   localparam int ADDRESS_BITS = 32;
   localparam int NODE_W       = $clog2(NODE_COUNT);
   localparam int FREE_W       = NODE_W + 1;
   localparam int LEVEL_W      = $clog2(ADDRESS_BITS + 1);
   localparam int NODE_BITS    = 2 * NODE_W + 32 + 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_POOL_FULL = 1'b1;

   typedef struct packed {
      logic [NODE_W-1:0] left;
      logic [NODE_W-1:0] right;
      logic [31:0]       hop_address;
      logic [7:0]        hop_port;
   } node_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_FRESH = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   function automatic logic [LEVEL_W-1:0] sat_len(input logic [5:0] plen);
      if (int'(plen) > ADDRESS_BITS) begin
         return LEVEL_W'(ADDRESS_BITS);
      end
      return LEVEL_W'(plen);
   endfunction

   function automatic logic addr_bit(input logic [31:0] a, input logic [LEVEL_W-1:0] lvl);
      int pos;
      pos = int'(lvl);
      if (pos < 32) begin
         return a[31 - pos];
      end
      return 1'b0;
   endfunction

endpackage

// ----- hdl/btlpm_ram.sv -----
// ----------------------------------------------------------------------------
// btlpm_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module btlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/binary_trie_longest_prefix_match_core.sv -----
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_core
// Flow: a zero-length insert goes straight to ST_DONE without a node access;
//   other items walk the trie from the root, a lookup down to ADDRESS_BITS.
// Throughput: one item at a time, one node memory read per trie level; the next
//   item is accepted after the result loads; rsp_stall can hold back the load.
// Reset: synchronous; clears control state, sets the free counter to one and
//   marks the root as empty; other node entries are undefined until written.
// ----------------------------------------------------------------------------
// Binary trie IPv4 route store with longest prefix match lookup over a
// single node memory.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_address,
   input  logic [5:0]  req_prefix_length,
   input  logic [31:0] req_next_hop_address,
   input  logic [7:0]  req_next_hop_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_route_address,
   output logic [7:0]  rsp_route_port,
   output logic        rsp_status
);

   localparam int NW = btlpm_pkg::NODE_W;
   localparam int FW = btlpm_pkg::FREE_W;
   localparam int LW = btlpm_pkg::LEVEL_W;

   btlpm_pkg::state_type state_ff, state_in;

   logic          op_ff;
   logic [31:0]   addr_ff;
   logic [LW-1:0] plen_ff;
   logic [31:0]   nh_addr_ff;
   logic [7:0]    nh_port_ff;

   logic [LW-1:0] level_ff, level_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [FW-1:0] next_free_ff, next_free_in;
   logic          root_valid_ff, root_valid_in;
   logic          rd_root_ff;

   logic          best_found_ff, best_found_in;
   logic [31:0]   best_addr_ff, best_addr_in;
   logic [7:0]    best_port_ff, best_port_in;

   logic          res_found_ff, res_found_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic [7:0]    res_port_ff, res_port_in;
   logic          res_status_ff, res_status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff;
   logic [31:0]   rsp_addr_ff;
   logic [7:0]    rsp_port_ff;
   logic          rsp_status_ff;

   logic                       ram_wr_en;
   logic [NW-1:0]              ram_wr_addr;
   btlpm_pkg::node_type        ram_wr_data;
   logic                       ram_rd_en;
   logic [NW-1:0]              ram_rd_addr;
   logic [btlpm_pkg::NODE_BITS-1:0] ram_rd_data;

   btlpm_pkg::node_type node_q;
   btlpm_pkg::node_type node_upd;
   btlpm_pkg::node_type node_link;
   logic          bit_val;
   logic [NW-1:0] child;
   logic          child_ok;
   logic          pool_full;
   logic          at_depth;
   logic          hit_now;
   logic          hit_any;
   logic [31:0]   hit_addr;
   logic [7:0]    hit_port;
   logic          rsp_load;
   logic          accept;
   logic [LW-1:0] req_plen_sat;

   btlpm_ram #(
      .WIDTH (btlpm_pkg::NODE_BITS),
      .DEPTH (btlpm_pkg::NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign node_q    = (rd_root_ff && !root_valid_ff) ? '0 : btlpm_pkg::node_type'(ram_rd_data);
   assign bit_val   = btlpm_pkg::addr_bit(addr_ff, level_ff);
   assign child     = bit_val ? node_q.right : node_q.left;
   assign child_ok  = (child != '0) && ({1'b0, child} < FW'(btlpm_pkg::NODE_COUNT));
   assign pool_full = next_free_ff >= FW'(btlpm_pkg::NODE_COUNT);
   assign at_depth  = level_ff == LW'(btlpm_pkg::ADDRESS_BITS);
   assign hit_now   = (level_ff != '0) && (node_q.hop_port != 8'd0);
   assign hit_any   = hit_now || best_found_ff;
   assign hit_addr  = hit_now ? node_q.hop_address : best_addr_ff;
   assign hit_port  = hit_now ? node_q.hop_port : best_port_ff;

   assign req_stall    = state_ff != btlpm_pkg::ST_IDLE;
   assign accept       = req_valid && !req_stall;
   assign req_plen_sat = btlpm_pkg::sat_len(req_prefix_length);
   assign rsp_load     = (state_ff == btlpm_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      node_upd = node_q;
      if (bit_val) begin
         node_upd.right = next_free_ff[NW-1:0];
      end else begin
         node_upd.left = next_free_ff[NW-1:0];
      end
      node_link = '0;
      if (bit_val) begin
         node_link.right = next_free_ff[NW-1:0];
      end else begin
         node_link.left = next_free_ff[NW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      cur_in        = cur_ff;
      next_free_in  = next_free_ff;
      best_found_in = best_found_ff;
      best_addr_in  = best_addr_ff;
      best_port_in  = best_port_ff;
      res_found_in  = res_found_ff;
      res_addr_in   = res_addr_ff;
      res_port_in   = res_port_ff;
      res_status_in = res_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         btlpm_pkg::ST_IDLE: begin
            if (accept) begin
               res_found_in  = 1'b0;
               res_addr_in   = '0;
               res_port_in   = '0;
               res_status_in = btlpm_pkg::STATUS_OK;
               if (req_op == btlpm_pkg::OP_INSERT && req_plen_sat == '0) begin
                  state_in = btlpm_pkg::ST_DONE;
               end else begin
                  ram_rd_en     = 1'b1;
                  level_in      = '0;
                  cur_in        = '0;
                  best_found_in = 1'b0;
                  best_addr_in  = '0;
                  best_port_in  = '0;
                  state_in      = btlpm_pkg::ST_WALK;
               end
            end
         end
         btlpm_pkg::ST_WALK: begin
            if (op_ff == btlpm_pkg::OP_LOOKUP) begin
               if (at_depth || !child_ok) begin
                  res_found_in = hit_any;
                  res_addr_in  = hit_any ? hit_addr : '0;
                  res_port_in  = hit_any ? hit_port : '0;
                  state_in     = btlpm_pkg::ST_DONE;
               end else begin
                  best_found_in = hit_any;
                  best_addr_in  = hit_addr;
                  best_port_in  = hit_port;
                  ram_rd_en     = 1'b1;
                  ram_rd_addr   = child;
                  cur_in        = child;
                  level_in      = level_ff + LW'(1);
               end
            end else begin
               if (level_ff == plen_ff) begin
                  ram_wr_en               = 1'b1;
                  ram_wr_data             = node_q;
                  ram_wr_data.hop_address = nh_addr_ff;
                  ram_wr_data.hop_port    = nh_port_ff;
                  state_in                = btlpm_pkg::ST_DONE;
               end else if (child_ok) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = child;
                  cur_in      = child;
                  level_in    = level_ff + LW'(1);
               end else if (pool_full) begin
                  res_status_in = btlpm_pkg::STATUS_POOL_FULL;
                  state_in      = btlpm_pkg::ST_DONE;
               end else begin
                  ram_wr_en    = 1'b1;
                  ram_wr_data  = node_upd;
                  cur_in       = next_free_ff[NW-1:0];
                  next_free_in = next_free_ff + FW'(1);
                  level_in     = level_ff + LW'(1);
                  state_in     = btlpm_pkg::ST_FRESH;
               end
            end
         end
         btlpm_pkg::ST_FRESH: begin
            ram_wr_en = 1'b1;
            if (level_ff == plen_ff) begin
               ram_wr_data.hop_address = nh_addr_ff;
               ram_wr_data.hop_port    = nh_port_ff;
               state_in                = btlpm_pkg::ST_DONE;
            end else if (pool_full) begin
               res_status_in = btlpm_pkg::STATUS_POOL_FULL;
               state_in      = btlpm_pkg::ST_DONE;
            end else begin
               ram_wr_data  = node_link;
               cur_in       = next_free_ff[NW-1:0];
               next_free_in = next_free_ff + FW'(1);
               level_in     = level_ff + LW'(1);
            end
         end
         btlpm_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = btlpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = btlpm_pkg::ST_IDLE;
         end
      endcase
   end

   assign root_valid_in = root_valid_ff || (ram_wr_en && ram_wr_addr == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= btlpm_pkg::ST_IDLE;
         next_free_ff  <= FW'(1);
         root_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         root_valid_ff <= root_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_op;
         addr_ff    <= req_address;
         plen_ff    <= req_plen_sat;
         nh_addr_ff <= req_next_hop_address;
         nh_port_ff <= req_next_hop_port;
      end
      if (ram_rd_en) begin
         rd_root_ff <= ram_rd_addr == '0;
      end
      level_ff      <= level_in;
      cur_ff        <= cur_in;
      best_found_ff <= best_found_in;
      best_addr_ff  <= best_addr_in;
      best_port_ff  <= best_port_in;
      res_found_ff  <= res_found_in;
      res_addr_ff   <= res_addr_in;
      res_port_ff   <= res_port_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_found_ff  <= res_found_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_port_ff   <= res_port_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_route_address = rsp_addr_ff;
   assign rsp_route_port    = rsp_port_ff;
   assign rsp_status        = rsp_status_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FW'(btlpm_pkg::NODE_COUNT))
      else $error("free counter beyond node pool");

   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == btlpm_pkg::ST_WALK || state_ff == btlpm_pkg::ST_FRESH))
      else $error("node write outside a walk");

   a_fresh_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == btlpm_pkg::ST_FRESH |-> !ram_rd_en)
      else $error("node read while building fresh nodes");

   a_idle_keeps_pool: assert property (@(posedge clock) disable iff (reset)
      state_ff == btlpm_pkg::ST_IDLE |=> next_free_ff == $past(next_free_ff))
      else $error("free counter moved while idle");

   a_full_no_route: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == btlpm_pkg::STATUS_POOL_FULL)
         |-> (!rsp_found_ff && rsp_port_ff == 8'd0))
      else $error("pool full item carries a route");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary trie longest prefix match core. Route
// inserts and address lookups go in over the request channel; a local trie
// model predicts every result, and each result that comes back is checked
// against the oldest prediction. Covers directed edge cases, clustered
// random routes, node pool exhaustion and traffic after the pool is full,
// with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int STUCK_LIMIT = 400;
   localparam int RANDOM_ITEMS = 1200;
   localparam int KNOWN_MAX = 256;

   typedef struct packed {
      logic        found;
      logic [31:0] address;
      logic [7:0]  port;
      logic        status;
   } route_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [31:0] req_address;
   logic [5:0]  req_prefix_length;
   logic [31:0] req_next_hop_address;
   logic [7:0]  req_next_hop_port;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_found;
   logic [31:0] rsp_route_address;
   logic [7:0]  rsp_route_port;
   logic        rsp_status;

   logic [btlpm_pkg::NODE_W-1:0] trie_left [btlpm_pkg::NODE_COUNT];
   logic [btlpm_pkg::NODE_W-1:0] trie_right[btlpm_pkg::NODE_COUNT];
   logic [31:0]       trie_hop_address[btlpm_pkg::NODE_COUNT];
   logic [7:0]        trie_hop_port[btlpm_pkg::NODE_COUNT];
   int                free_node;

   route_result_type  pending_routes[$];
   logic [31:0]       known_prefix[$];
   int                known_len[$];
   logic [31:0]       route_bases[6];

   bit calm_phase;
   int insert_count;
   int lookup_count;
   int match_count;
   int pool_full_count;
   int result_count;
   int mismatch_count;

   binary_trie_longest_prefix_match_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_address          (req_address),
      .req_prefix_length    (req_prefix_length),
      .req_next_hop_address (req_next_hop_address),
      .req_next_hop_port    (req_next_hop_port),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_route_address    (rsp_route_address),
      .rsp_route_port       (rsp_route_port),
      .rsp_status           (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait();
      if (calm_phase) begin
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [7:0] random_port();
      if ($urandom_range(0, 7) == 0) begin
         return 8'd0;
      end
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic route_result_type predict_route(input btlpm_pkg::op_type op,
                                                      input logic [31:0] addr,
                                                      input logic [5:0] plen,
                                                      input logic [31:0] hop_addr,
                                                      input logic [7:0] hop_port);
      route_result_type res;
      int depth;
      int cur;
      int nxt;
      int lvl;
      logic branch;
      res = '0;
      cur = 0;
      if (op == btlpm_pkg::OP_INSERT) begin
         insert_count++;
         depth = (int'(plen) > btlpm_pkg::ADDRESS_BITS) ? btlpm_pkg::ADDRESS_BITS
                                                         : int'(plen);
         for (lvl = 0; lvl < depth; lvl++) begin
            branch = (lvl < 32) ? addr[31 - lvl] : 1'b0;
            nxt = branch ? int'(trie_right[cur]) : int'(trie_left[cur]);
            if (nxt == 0 || nxt >= btlpm_pkg::NODE_COUNT) begin
               if (free_node >= btlpm_pkg::NODE_COUNT) begin
                  res.status = btlpm_pkg::STATUS_POOL_FULL;
                  pool_full_count++;
                  return res;
               end
               nxt = free_node;
               free_node++;
               trie_left[nxt] = '0;
               trie_right[nxt] = '0;
               trie_hop_address[nxt] = '0;
               trie_hop_port[nxt] = '0;
               if (branch) begin
                  trie_right[cur] = btlpm_pkg::NODE_W'(nxt);
               end else begin
                  trie_left[cur] = btlpm_pkg::NODE_W'(nxt);
               end
            end
            cur = nxt;
         end
         if (depth > 0) begin
            trie_hop_address[cur] = hop_addr;
            trie_hop_port[cur] = hop_port;
         end
         res.status = btlpm_pkg::STATUS_OK;
      end else begin
         lookup_count++;
         for (lvl = 0; lvl < btlpm_pkg::ADDRESS_BITS; lvl++) begin
            branch = (lvl < 32) ? addr[31 - lvl] : 1'b0;
            nxt = branch ? int'(trie_right[cur]) : int'(trie_left[cur]);
            if (nxt == 0 || nxt >= btlpm_pkg::NODE_COUNT) begin
               break;
            end
            cur = nxt;
            if (trie_hop_port[cur] != 8'd0) begin
               res.found = 1'b1;
               res.address = trie_hop_address[cur];
               res.port = trie_hop_port[cur];
            end
         end
         if (res.found) begin
            match_count++;
         end
      end
      return res;
   endfunction

   // Pick a stored prefix; lookups: random bits past it, maybe one bit flipped.
   function automatic logic [31:0] known_address(input bit for_lookup);
      int idx;
      logic [63:0] wide;
      logic [31:0] mask;
      logic [31:0] addr;
      idx = $urandom_range(0, known_prefix.size() - 1);
      addr = known_prefix[idx];
      if (for_lookup) begin
         wide = {32'hFFFF_FFFF, 32'h0} >> known_len[idx];
         mask = wide[31:0];
         addr = (addr & mask) | ($urandom & ~mask);
         if ($urandom_range(0, 3) == 0) begin
            addr[$urandom_range(0, 31)] ^= 1'b1;
         end
      end
      return addr;
   endfunction

   task automatic remember_prefix(input logic [31:0] addr, input logic [5:0] plen);
      if (plen != 6'd0) begin
         known_prefix.push_back(addr);
         known_len.push_back((int'(plen) > 32) ? 32 : int'(plen));
         if (known_prefix.size() > KNOWN_MAX) begin
            void'(known_prefix.pop_front());
            void'(known_len.pop_front());
         end
      end
   endtask

   task automatic send_item(input btlpm_pkg::op_type op, input logic [31:0] addr,
                            input logic [5:0] plen, input logic [31:0] hop_addr,
                            input logic [7:0] hop_port);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= addr;
      req_prefix_length <= plen;
      req_next_hop_address <= hop_addr;
      req_next_hop_port <= hop_port;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_routes.push_back(predict_route(op, addr, plen, hop_addr, hop_port));
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_routes.size() != 0);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("ERROR: %s", what);
      end
   endtask

   task automatic test_directed_routes();
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'd255);
      // zero-length prefix stores nothing
      send_item(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF, 8'd255);
      send_item(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 8'd255);
      // over-long prefix saturates to the full address
      send_item(btlpm_pkg::OP_INSERT, 32'h0000_0000, 6'd63, 32'h0102_0304, 8'd1);
      send_item(btlpm_pkg::OP_INSERT, 32'h8000_0000, 6'd1, 32'hA5A5_A5A5, 8'h80);
      send_item(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0000_0001, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 32'h0A00_0001, 8'd10);
      send_item(btlpm_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0A01_0001, 8'd20);
      send_item(btlpm_pkg::OP_INSERT, 32'h0A01_0100, 6'd24, 32'h0A01_0101, 8'd30);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0A01_01FF, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0A01_FF00, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0A7F_0000, 6'd0, 32'h0, 8'd0);
      // port 0 clears the route at that node
      send_item(btlpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'h1234_5678, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_INSERT, 32'h5555_5555, 6'd33, 32'hAAAA_AAAA, 8'd7);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h5555_5555, 6'd63, 32'hFFFF_FFFF, 8'hFF);
      send_item(btlpm_pkg::OP_INSERT, 32'h0000_0000, 6'd32, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 8'd0);
      send_item(btlpm_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 6'd0, 32'h0, 8'd0);
   endtask

   task automatic test_random_routes();
      int n;
      int pick;
      int len_pick;
      logic [31:0] addr;
      logic [5:0] plen;
      for (n = 0; n < 6; n++) begin
         route_bases[n] = $urandom;
      end
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            calm_phase = ($urandom_range(0, 2) == 0);
         end
         if (n == RANDOM_ITEMS / 2) begin
            hold_until_drained();
         end
         pick = $urandom_range(0, 9);
         if ($urandom_range(0, 99) < 45) begin
            if (known_prefix.size() != 0 && pick >= 4) begin
               addr = known_address(1'b1);
            end else if (pick >= 1) begin
               addr = (route_bases[$urandom_range(0, 5)] & 32'hFFF0_0000) |
                      ($urandom & 32'h000F_FFFF);
            end else begin
               addr = $urandom;
            end
            send_item(btlpm_pkg::OP_LOOKUP, addr, 6'($urandom), $urandom, 8'($urandom));
         end else begin
            if (known_prefix.size() != 0 && (pick >= 6 || free_node > 3400)) begin
               addr = known_address(1'b0);
            end else if (pick >= 2) begin
               addr = (route_bases[$urandom_range(0, 5)] & 32'hFFF0_0000) |
                      ($urandom & 32'h000F_FFFF);
            end else begin
               addr = $urandom;
            end
            len_pick = $urandom_range(0, 19);
            if (len_pick == 0) begin
               plen = 6'd0;
            end else if (len_pick <= 10) begin
               plen = 6'($urandom_range(1, 20));
            end else if (len_pick <= 16) begin
               plen = 6'($urandom_range(21, 32));
            end else begin
               plen = 6'($urandom_range(33, 63));
            end
            send_item(btlpm_pkg::OP_INSERT, addr, plen, $urandom, random_port());
            remember_prefix(addr, plen);
         end
      end
      calm_phase = 1'b0;
   endtask

   task automatic test_pool_exhaustion();
      int tries;
      int full_goal;
      logic [31:0] addr;
      full_goal = pool_full_count + 6;
      tries = 0;
      while (pool_full_count < full_goal && tries < 1000) begin
         addr = $urandom;
         send_item(btlpm_pkg::OP_INSERT, addr, 6'd32, $urandom,
                   8'($urandom_range(1, 255)));
         remember_prefix(addr, 6'd32);
         tries++;
      end
   endtask

   task automatic test_after_exhaustion();
      int n;
      int pick;
      for (n = 0; n < 80; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            send_item(btlpm_pkg::OP_INSERT, known_address(1'b0),
                      6'($urandom_range(1, 32)), $urandom, random_port());
         end else if (pick < 6) begin
            send_item(btlpm_pkg::OP_INSERT, $urandom, 6'($urandom_range(1, 63)),
                      $urandom, random_port());
         end else begin
            send_item(btlpm_pkg::OP_LOOKUP, known_address(1'b1), 6'($urandom),
                      $urandom, 8'($urandom));
         end
      end
   endtask

   initial begin : result_checker
      int hold;
      route_result_type want;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         result_count++;
         if (pending_routes.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      result_count));
         end else begin
            want = pending_routes.pop_front();
            if (rsp_found !== want.found || rsp_route_address !== want.address ||
                rsp_route_port !== want.port || rsp_status !== want.status) begin
               report_mismatch($sformatf({"result %0d expected found %b address %h ",
                  "port %0d status %b, got found %b address %h port %0d status %b"},
                  result_count, want.found, want.address, want.port, want.status,
                  rsp_found, rsp_route_address, rsp_route_port, rsp_status));
            end
         end
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            stuck = 0;
         end else begin
            stuck++;
         end
      end
      $display("Timeout: no item moved for %0d cycles", STUCK_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= btlpm_pkg::OP_INSERT;
      req_address <= '0;
      req_prefix_length <= '0;
      req_next_hop_address <= '0;
      req_next_hop_port <= '0;
      calm_phase = 1'b0;
      for (n = 0; n < btlpm_pkg::NODE_COUNT; n++) begin
         trie_left[n] = '0;
         trie_right[n] = '0;
         trie_hop_address[n] = '0;
         trie_hop_port[n] = '0;
      end
      free_node = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_routes();
      hold_until_drained();
      test_random_routes();
      hold_until_drained();
      test_pool_exhaustion();
      hold_until_drained();
      test_after_exhaustion();
      hold_until_drained();
      repeat (btlpm_pkg::ADDRESS_BITS + 8) @(posedge clock);
      if (pending_routes.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_routes.size()));
      end
      $display("Covered %0d inserts (%0d with the node pool full) and %0d lookups",
               insert_count, pool_full_count, lookup_count);
      $display("Lookups with a route: %0d; nodes taken: %0d of %0d; errors: %0d",
               match_count, free_node, btlpm_pkg::NODE_COUNT, mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
